// ----- rtl/slt_pkg.sv -----
package slt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int COUNT_W = 5;
	localparam int TOT_W = COUNT_W + 2;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W = 4;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_MAGNET = 2'd1;
	localparam logic [1:0] REG_PIR = 2'd2;

	localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
	localparam logic [7:0] MAGNET_CODE_RESET = 8'd1;
	localparam logic [7:0] PIR_CODE_RESET = 8'd2;

	localparam logic [1:0] ITEM_MSG = 2'd0;
	localparam logic [1:0] ITEM_SWEEP = 2'd1;
	localparam logic [1:0] ITEM_CLEAR = 2'd2;

	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_MAGNET = 2'd1;
	localparam logic [1:0] KIND_PIR = 2'd2;

	localparam logic [1:0] OP_NOP = 2'd0;
	localparam logic [1:0] OP_MSG = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] sensor_type;
		logic [7:0] sensor_id;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic accepted;
		logic renewed;
		logic is_new;
		logic any_expired;
		logic [COUNT_W-1:0] magnet_count;
		logic [COUNT_W-1:0] pir_count;
	} result_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] new_kind;
		logic accepted;
		logic [7:0] sensor_id;
		logic [31:0] now_ms;
	} cmd_t;

endpackage

// ----- rtl/slt_front.sv -----
module slt_front (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [slt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	input  logic item_valid,
	output logic item_stall,
	input  slt_pkg::item_t item,
	output logic push,
	output slt_pkg::cmd_t cmd,
	input  logic queue_full,
	output logic [31:0] max_age
);

	logic [31:0] timeout_q;
	logic [7:0] magnet_code_q;
	logic [7:0] pir_code_q;
	logic [1:0] reg_idx;
	logic [1:0] new_kind;
	logic msg_ok;

	assign reg_idx = paddr[3:2];
	assign max_age = timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= slt_pkg::TIMEOUT_RESET;
			magnet_code_q <= slt_pkg::MAGNET_CODE_RESET;
			pir_code_q <= slt_pkg::PIR_CODE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				slt_pkg::REG_TIMEOUT: timeout_q <= pwdata;
				slt_pkg::REG_MAGNET: magnet_code_q <= pwdata[7:0];
				slt_pkg::REG_PIR: pir_code_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			slt_pkg::REG_TIMEOUT: prdata = timeout_q;
			slt_pkg::REG_MAGNET: prdata = {24'd0, magnet_code_q};
			slt_pkg::REG_PIR: prdata = {24'd0, pir_code_q};
			default: prdata = 32'd0;
		endcase
	end

	// Magnet wins when both type registers hold the same code.
	always_comb begin
		priority if (item.sensor_type == magnet_code_q) begin
			new_kind = slt_pkg::KIND_MAGNET;
		end else if (item.sensor_type == pir_code_q) begin
			new_kind = slt_pkg::KIND_PIR;
		end else begin
			new_kind = slt_pkg::KIND_EMPTY;
		end
	end

	assign msg_ok = (new_kind != slt_pkg::KIND_EMPTY) && (item.sensor_id != 8'd0);

	always_comb begin
		cmd.new_kind = new_kind;
		cmd.sensor_id = item.sensor_id;
		cmd.now_ms = item.now_ms;
		cmd.accepted = 1'b0;
		unique case (item.kind)
			slt_pkg::ITEM_MSG: begin
				cmd.op = msg_ok ? slt_pkg::OP_MSG : slt_pkg::OP_NOP;
				cmd.accepted = msg_ok;
			end
			slt_pkg::ITEM_SWEEP: cmd.op = slt_pkg::OP_SWEEP;
			slt_pkg::ITEM_CLEAR: cmd.op = slt_pkg::OP_CLEAR;
			default: cmd.op = slt_pkg::OP_NOP;
		endcase
	end

	assign item_stall = queue_full;
	assign push = item_valid && !queue_full;

endmodule

// ----- rtl/slt_queue.sv -----
module slt_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  slt_pkg::cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic cmd_valid,
	output slt_pkg::cmd_t cmd
);

	slt_pkg::cmd_t slot_q [slt_pkg::QUEUE_DEPTH];
	logic [slt_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [slt_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [slt_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == slt_pkg::QCNT_W'(slt_pkg::QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && cmd_valid;

	function automatic logic [slt_pkg::QPTR_W-1:0] ptr_inc(
		input logic [slt_pkg::QPTR_W-1:0] p
	);
		if (p == slt_pkg::QPTR_W'(slt_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/slt_back.sv -----
module slt_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  slt_pkg::cmd_t cmd,
	output logic pop,
	input  logic [31:0] max_age,
	output logic result_valid,
	input  logic result_stall,
	output slt_pkg::result_t result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	slt_pkg::cmd_t cmd_q;
	logic [slt_pkg::IDX_W-1:0] idx_q;
	logic [slt_pkg::IDX_W-1:0] hit_idx_q;
	logic [slt_pkg::IDX_W-1:0] empty_idx_q;
	logic hit_q;
	logic empty_found_q;
	logic expired_q;

	logic [1:0] kind_q [slt_pkg::TABLE_ENTRIES];
	logic [7:0] id_q [slt_pkg::TABLE_ENTRIES];
	logic [31:0] lease_q [slt_pkg::TABLE_ENTRIES];
	logic [slt_pkg::COUNT_W-1:0] magnet_q;
	logic [slt_pkg::COUNT_W-1:0] pir_q;

	logic out_valid_q;
	slt_pkg::result_t out_q;

	logic last;
	logic fin_ok;
	logic [31:0] age;
	logic expire;
	logic ins_ok;
	logic [slt_pkg::TOT_W-1:0] total;
	logic [slt_pkg::COUNT_W-1:0] magnet_next;
	logic [slt_pkg::COUNT_W-1:0] pir_next;
	slt_pkg::result_t res;

	assign pop = (state_q == ST_IDLE) && cmd_valid;
	assign last = (idx_q == slt_pkg::IDX_W'(slt_pkg::TABLE_ENTRIES - 1));
	assign fin_ok = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result = out_q;

	// Lease age wraps with the millisecond clock.
	assign age = cmd_q.now_ms - lease_q[idx_q];
	assign expire = (id_q[idx_q] != 8'd0) && (age > max_age);

	assign total = slt_pkg::TOT_W'(magnet_q) + slt_pkg::TOT_W'(pir_q);
	assign ins_ok = (cmd_q.op == slt_pkg::OP_MSG) && !hit_q && empty_found_q &&
		(total < slt_pkg::TOT_W'(slt_pkg::TABLE_ENTRIES));

	always_comb begin
		magnet_next = magnet_q;
		pir_next = pir_q;
		if (cmd_q.op == slt_pkg::OP_CLEAR) begin
			magnet_next = '0;
			pir_next = '0;
		end else if (ins_ok) begin
			if (cmd_q.new_kind == slt_pkg::KIND_MAGNET) begin
				if (magnet_q < slt_pkg::COUNT_MAX) begin
					magnet_next = magnet_q + 1'b1;
				end
			end else if (pir_q < slt_pkg::COUNT_MAX) begin
				pir_next = pir_q + 1'b1;
			end
		end
	end

	always_comb begin
		res.accepted = cmd_q.accepted;
		res.renewed = (cmd_q.op == slt_pkg::OP_MSG) && hit_q;
		res.is_new = ins_ok;
		res.any_expired = expired_q;
		res.magnet_count = magnet_next;
		res.pir_count = pir_next;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_FINISH && fin_ok) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			hit_idx_q <= '0;
			empty_idx_q <= '0;
			hit_q <= 1'b0;
			empty_found_q <= 1'b0;
			expired_q <= 1'b0;
			magnet_q <= '0;
			pir_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < slt_pkg::TABLE_ENTRIES; i++) begin
				kind_q[i] <= slt_pkg::KIND_EMPTY;
				id_q[i] <= 8'd0;
				lease_q[i] <= 32'd0;
			end
		end else begin
			if (out_valid_q && !result_stall && !(state_q == ST_FINISH && fin_ok)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						empty_found_q <= 1'b0;
						expired_q <= 1'b0;
						unique case (cmd.op)
							slt_pkg::OP_MSG: state_q <= ST_SCAN;
							slt_pkg::OP_SWEEP: state_q <= ST_SWEEP;
							slt_pkg::OP_CLEAR, slt_pkg::OP_NOP: state_q <= ST_FINISH;
						endcase
					end
				end
				ST_SCAN: begin
					if (id_q[idx_q] == cmd_q.sensor_id) begin
						hit_q <= 1'b1;
						hit_idx_q <= idx_q;
						state_q <= ST_FINISH;
					end else begin
						if (kind_q[idx_q] == slt_pkg::KIND_EMPTY && !empty_found_q) begin
							empty_found_q <= 1'b1;
							empty_idx_q <= idx_q;
						end
						if (last) begin
							state_q <= ST_FINISH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					if (expire) begin
						// Only a decrement of a nonzero count marks the beat expired.
						if (kind_q[idx_q] == slt_pkg::KIND_PIR) begin
							if (pir_q != '0) begin
								pir_q <= pir_q - 1'b1;
								expired_q <= 1'b1;
							end
						end else if (kind_q[idx_q] == slt_pkg::KIND_MAGNET) begin
							if (magnet_q != '0) begin
								magnet_q <= magnet_q - 1'b1;
								expired_q <= 1'b1;
							end
						end
						kind_q[idx_q] <= slt_pkg::KIND_EMPTY;
						id_q[idx_q] <= 8'd0;
						lease_q[idx_q] <= 32'd0;
					end
					if (last) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (fin_ok) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
						magnet_q <= magnet_next;
						pir_q <= pir_next;
						if (cmd_q.op == slt_pkg::OP_MSG && hit_q) begin
							lease_q[hit_idx_q] <= cmd_q.now_ms;
						end else if (ins_ok) begin
							kind_q[empty_idx_q] <= cmd_q.new_kind;
							id_q[empty_idx_q] <= cmd_q.sensor_id;
							lease_q[empty_idx_q] <= cmd_q.now_ms;
						end
						if (cmd_q.op == slt_pkg::OP_CLEAR) begin
							for (int i = 0; i < slt_pkg::TABLE_ENTRIES; i++) begin
								kind_q[i] <= slt_pkg::KIND_EMPTY;
								id_q[i] <= 8'd0;
								lease_q[i] <= 32'd0;
							end
						end
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/sensor_lease_table.sv -----
// Sensor lease table: sixteen entries of sensor kind, node id and lease time.
// Input channel (item, item_valid, item_stall) takes one beat per item: a
// sensor message, an expiry sweep or a table clear. Output channel (result,
// result_valid, result_stall) returns one beat per item, in order.
// The front classifies each beat against the type code registers and places
// it in a two-deep command queue; the back walks the table one entry a cycle.
// A clear or an ignored message skips the walk; a sweep visits every entry,
// and a message stops at the entry that holds its id. The back takes a new
// item from the queue only once it has finished the last one, so a sweep or
// a message whose id is not in the table keeps the back busy for the whole walk.
// Reset empties the table, zeroes both counts and loads the register defaults
// (timeout 30000 ms, magnet code 1, PIR code 2); the clear item empties the
// table the same way but keeps the registers.
// A stalled result holds in the output register; the back finishes no further
// item until it is taken, while the queue still absorbs up to two items.
// Registers over APB, 32-bit words: 0x0 lease timeout, 0x4 magnet code,
// 0x8 PIR code. Write them only while the block is idle.
module sensor_lease_table (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [slt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic item_valid,
	output logic item_stall,
	input  slt_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output slt_pkg::result_t result
);

	logic push;
	slt_pkg::cmd_t push_cmd;
	logic queue_full;
	logic pop;
	logic cmd_valid;
	slt_pkg::cmd_t cmd;
	logic [31:0] max_age;

	assign pready = 1'b1;

	slt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.push(push),
		.cmd(push_cmd),
		.queue_full(queue_full),
		.max_age(max_age)
	);

	slt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(pop),
		.cmd_valid(cmd_valid),
		.cmd(cmd)
	);

	slt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.pop(pop),
		.max_age(max_age),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

// ----- rtl/slt_checker.sv -----
module slt_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic result_valid,
	input  logic result_stall,
	input  slt_pkg::result_t result
);

	// A held result beat keeps its contents until taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (slt_pkg::TOT_W'(result.magnet_count) +
			slt_pkg::TOT_W'(result.pir_count)) <= slt_pkg::TOT_W'(slt_pkg::TABLE_ENTRIES))
		else $error("combined count exceeds table capacity");

	a_flag_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.any_expired |-> !result.accepted)
		else $error("expiry reported on a message beat");

	a_msg_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.renewed || result.is_new) |->
			result.accepted && !(result.renewed && result.is_new))
		else $error("renewed and new flags inconsistent");

endmodule

bind sensor_lease_table slt_checker u_slt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result(result)
);

// ----- tb/sensor_lease_table_tb.sv -----
module sensor_lease_table_tb;
	import slt_pkg::*;

	localparam logic [1:0] ITEM_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 24;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	sensor_lease_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Shadow of the table and its registers, advanced once per accepted beat.
	logic [31:0] lease_limit;
	logic [7:0] magnet_code;
	logic [7:0] pir_code;
	logic [1:0] slot_kind [TABLE_ENTRIES];
	logic [7:0] slot_id [TABLE_ENTRIES];
	logic [31:0] slot_lease [TABLE_ENTRIES];
	logic [COUNT_W-1:0] magnet_held;
	logic [COUNT_W-1:0] pir_held;

	result_t expected_status [$];
	result_t want_status;
	int fail_count = 0;
	int cycle_count = 0;
	bit src_idle = 1'b1;
	bit sink_idle = 1'b1;
	bit long_hold_req = 1'b0;
	logic [31:0] now_track = 32'd0;

	always #5 clk = ~clk;

	function automatic void empty_table();
		int i;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			slot_kind[i] = KIND_EMPTY;
			slot_id[i] = 8'd0;
			slot_lease[i] = 32'd0;
		end
		magnet_held = '0;
		pir_held = '0;
	endfunction

	function automatic result_t apply_to_table(item_t it);
		result_t r;
		logic [1:0] new_kind;
		logic [31:0] age;
		int i;
		r = '0;
		if (it.kind == ITEM_MSG) begin
			new_kind = KIND_EMPTY;
			// With equal codes the magnet match wins.
			if (it.sensor_type == magnet_code) begin
				new_kind = KIND_MAGNET;
			end else if (it.sensor_type == pir_code) begin
				new_kind = KIND_PIR;
			end
			if (new_kind != KIND_EMPTY && it.sensor_id != 8'd0) begin
				r.accepted = 1'b1;
				for (i = 0; i < TABLE_ENTRIES && !r.renewed; i++) begin
					if (slot_id[i] == it.sensor_id) begin
						slot_lease[i] = it.now_ms;
						r.renewed = 1'b1;
					end
				end
				if (!r.renewed && int'(magnet_held) + int'(pir_held) < TABLE_ENTRIES) begin
					for (i = 0; i < TABLE_ENTRIES && !r.is_new; i++) begin
						if (slot_kind[i] == KIND_EMPTY) begin
							slot_kind[i] = new_kind;
							slot_id[i] = it.sensor_id;
							slot_lease[i] = it.now_ms;
							if (new_kind == KIND_MAGNET) begin
								if (magnet_held != COUNT_MAX) magnet_held = magnet_held + 1'b1;
							end else begin
								if (pir_held != COUNT_MAX) pir_held = pir_held + 1'b1;
							end
							r.is_new = 1'b1;
						end
					end
				end
			end
		end else if (it.kind == ITEM_SWEEP) begin
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				age = it.now_ms - slot_lease[i];
				if (slot_id[i] != 8'd0 && age > lease_limit) begin
					if (slot_kind[i] == KIND_PIR) begin
						if (pir_held != '0) begin
							pir_held = pir_held - 1'b1;
							r.any_expired = 1'b1;
						end
					end else if (slot_kind[i] == KIND_MAGNET) begin
						if (magnet_held != '0) begin
							magnet_held = magnet_held - 1'b1;
							r.any_expired = 1'b1;
						end
					end
					slot_kind[i] = KIND_EMPTY;
					slot_id[i] = 8'd0;
					slot_lease[i] = 32'd0;
				end
			end
		end else if (it.kind == ITEM_CLEAR) begin
			empty_table();
		end
		r.magnet_count = magnet_held;
		r.pir_count = pir_held;
		return r;
	endfunction

	function automatic item_t make_item(logic [1:0] kind, logic [7:0] stype, logic [7:0] sid,
		logic [31:0] now);
		item_t it;
		it.kind = kind;
		it.sensor_type = stype;
		it.sensor_id = sid;
		it.now_ms = now;
		return it;
	endfunction

	// Mostly well-formed traffic on a running clock; the rest is noise that
	// the block reports on and mostly ignores.
	function automatic item_t random_item(int id_max, int step_max, output bit counts);
		item_t it;
		int pick;
		it.kind = ITEM_MSG;
		it.sensor_type = 8'($urandom_range(0, 255));
		it.sensor_id = 8'($urandom_range(0, 255));
		it.now_ms = $urandom;
		counts = 1'b1;
		now_track = now_track + $urandom_range(0, step_max);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			it.sensor_type = $urandom_range(0, 1) ? magnet_code : pir_code;
			it.sensor_id = 8'($urandom_range(1, id_max));
			it.now_ms = now_track;
		end else if (pick < 75) begin
			it.kind = ITEM_SWEEP;
			it.now_ms = now_track;
		end else if (pick < 78) begin
			it.kind = ITEM_CLEAR;
		end else if (pick < 82) begin
			it.kind = ITEM_UNUSED;
			counts = 1'b0;
		end else if (pick < 91) begin
			it.sensor_type = magnet_code;
			it.sensor_id = 8'd0;
			counts = 1'b0;
		end else begin
			counts = 1'b0;
		end
		return it;
	endfunction

	task automatic send_item(item_t it);
		@(negedge clk);
		if (src_idle && $urandom_range(0, 5) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		expected_status.push_back(apply_to_table(it));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		item_valid = 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		logic [31:0] stored;
		stored = (idx == REG_TIMEOUT) ? value : {24'd0, value[7:0]};
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// Read the register straight back.
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== stored) begin
			$error("register %0d readback: expected %0h, got %0h", idx, stored, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_TIMEOUT: lease_limit = value;
			REG_MAGNET: magnet_code = value[7:0];
			REG_PIR: pir_code = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] timeout, logic [7:0] mcode, logic [7:0] pcode);
		wait_idle();
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_MAGNET, {24'd0, mcode});
		write_reg(REG_PIR, {24'd0, pcode});
	endtask

	task automatic run_traffic(int items, int id_max, int step_max);
		item_t it;
		bit counts;
		int useful;
		useful = 0;
		while (useful < items) begin
			it = random_item(id_max, step_max, counts);
			send_item(it);
			if (counts) useful++;
		end
	endtask

	task automatic test_directed_defaults();
		send_item(make_item(ITEM_MSG, 8'd1, 8'd1, 32'd0));
		send_item(make_item(ITEM_MSG, 8'd2, 8'd255, 32'hFFFF_FFFF));
		// A PIR message renews a magnet entry with the same id.
		send_item(make_item(ITEM_MSG, 8'd2, 8'd1, 32'd100));
		send_item(make_item(ITEM_MSG, 8'd1, 8'd0, 32'd200));
		send_item(make_item(ITEM_MSG, 8'd0, 8'd5, 32'd200));
		send_item(make_item(ITEM_MSG, 8'd255, 8'd5, 32'd200));
		send_item(make_item(ITEM_UNUSED, 8'd1, 8'd7, 32'h1234_5678));
		// Age equal to the timeout stays; one more millisecond expires it.
		send_item(make_item(ITEM_SWEEP, 8'd0, 8'd0, 32'd30100));
		send_item(make_item(ITEM_SWEEP, 8'hFF, 8'hFF, 32'd30101));
		send_item(make_item(ITEM_MSG, 8'd1, 8'h80, 32'hFFFF_FF00));
		send_item(make_item(ITEM_SWEEP, 8'd0, 8'd0, 32'h0000_0100));
		send_item(make_item(ITEM_MSG, 8'd2, 8'h7F, 32'h5555_5555));
		send_item(make_item(ITEM_MSG, 8'd1, 8'hAA, 32'hAAAA_AAAA));
		send_item(make_item(ITEM_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
		send_item(make_item(ITEM_SWEEP, 8'd0, 8'd0, 32'hFFFF_FFFF));
		send_item(make_item(ITEM_MSG, 8'd2, 8'd3, 32'd0));
	endtask

	task automatic test_register_edges();
		set_config(32'd0, 8'd255, 8'd255);
		send_item(make_item(ITEM_MSG, 8'd255, 8'd9, 32'd50));
		send_item(make_item(ITEM_SWEEP, 8'd0, 8'd0, 32'd50));
		send_item(make_item(ITEM_SWEEP, 8'd0, 8'd0, 32'd51));
		set_config(32'hFFFF_FFFF, 8'd1, 8'd254);
		send_item(make_item(ITEM_MSG, 8'd254, 8'd10, 32'd0));
		send_item(make_item(ITEM_MSG, 8'd1, 8'd11, 32'h8000_0000));
		send_item(make_item(ITEM_SWEEP, 8'd0, 8'd0, 32'hFFFF_FFFF));
	endtask

	task automatic test_random_traffic();
		set_config(32'd30000, 8'd1, 8'd2);
		now_track = 32'd0;
		run_traffic(150, 24, 9000);
		// Nothing expires here, so the table fills and new ids get dropped.
		set_config(32'hFFFF_FFFF, 8'd255, 8'd1);
		run_traffic(120, 40, 100000);
		set_config(32'd0, 8'd9, 8'd9);
		run_traffic(120, 20, 2);
		set_config(32'd1000, 8'd3, 8'd200);
		now_track = 32'hFFFF_F000;
		run_traffic(150, 20, 400);
	endtask

	task automatic test_backpressure();
		set_config(32'd5000, 8'd1, 8'd2);
		src_idle = 1'b0;
		long_hold_req = 1'b1;
		run_traffic(40, 16, 1500);
		src_idle = 1'b1;
	endtask

	task automatic test_unthrottled();
		set_config(32'd5000, 8'd1, 8'd2);
		src_idle = 1'b0;
		sink_idle = 1'b0;
		run_traffic(300, 24, 1500);
	endtask

	task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_status.size() == 0) begin
				$error("result beat with nothing outstanding");
				fail_count++;
			end else begin
				want_status = expected_status.pop_front();
				check_field("accepted", 8'(want_status.accepted), 8'(result.accepted));
				check_field("renewed", 8'(want_status.renewed), 8'(result.renewed));
				check_field("is_new", 8'(want_status.is_new), 8'(result.is_new));
				check_field("any_expired", 8'(want_status.any_expired),
					8'(result.any_expired));
				check_field("magnet_count", 8'(want_status.magnet_count),
					8'(result.magnet_count));
				check_field("pir_count", 8'(want_status.pir_count), 8'(result.pir_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: short random stalls, plus one long hold on request.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				result_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				result_stall = 1'b0;
				long_hold_req = 1'b0;
			end else if (sink_idle && $urandom_range(0, 7) == 0) begin
				result_stall = 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				result_stall = 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		item_valid = 1'b0;
		item = '0;
		lease_limit = TIMEOUT_RESET;
		magnet_code = MAGNET_CODE_RESET;
		pir_code = PIR_CODE_RESET;
		empty_table();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_defaults();
		test_register_edges();
		test_random_traffic();
		test_backpressure();
		test_unthrottled();
		wait_idle();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
